>>> design/tmb_pkg.sv
// tmb_pkg: shared types and constants for the trimmed mean block
// no dependencies; imported by tmb_cell and trimmed_mean_of_block
`timescale 1ns / 1ps
package tmb_pkg;

   // blocks shorter than this give the middle sorted element
   localparam int TRIM_THRESHOLD = 5;
   // samples dropped at each end of a long block
   localparam int TRIM_EACH_SIDE = 2;

   // per-cycle command broadcast to every cell of the sorting chain
   typedef struct packed {
      logic insert;  // place the new sample in sorted position
      logic shift;   // move every entry one cell toward the head
   } cell_ctl_type;

endpackage

>>> design/tmb_cell.sv
// tmb_cell: one slot of the insertion sorting chain
// depends on tmb_pkg (cell_ctl_type)
`timescale 1ns / 1ps
module tmb_cell import tmb_pkg::*; #(
   parameter int W = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  logic [W-1:0] new_sample,
   input  logic [W-1:0] left_val,
   input  logic         left_valid,
   input  logic         left_take,
   input  logic [W-1:0] right_val,
   input  logic         right_valid,
   output logic [W-1:0] val,
   output logic         valid,
   output logic         take
);

   logic [W-1:0] val_ff, val_in;
   logic         valid_ff, valid_in;

   // new sample belongs at or before this slot (empty slots count as infinite)
   assign take = !valid_ff || (new_sample < val_ff);

   always_comb begin
      val_in   = val_ff;
      valid_in = valid_ff;
      if (ctl.shift) begin
         val_in   = right_val;
         valid_in = right_valid;
      end else if (ctl.insert) begin
         if (take) begin
            val_in = left_take ? left_val : new_sample;
         end
         valid_in = valid_ff | left_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      val_ff <= val_in;
   end

   assign val   = val_ff;
   assign valid = valid_ff;

endmodule

>>> design/tmb_div.sv
// tmb_div: restoring divider, one quotient bit per cycle
// no package dependencies
`timescale 1ns / 1ps
module tmb_div #(
   parameter int DW = 20,
   parameter int VW = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [VW:0]   rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] div_ff, div_in;
   logic [VW:0]   shifted;
   logic          fits;

   assign shifted = {rem_ff[VW-1:0], quo_ff[DW-1]};
   assign fits    = shifted >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? (shifted - {1'b0, div_ff}) : shifted;
         quo_in = {quo_ff[DW-2:0], fits};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> design/trimmed_mean_of_block.sv
// trimmed_mean_of_block: trimmed mean of a block of unsigned samples
// depends on tmb_pkg, tmb_cell (sorting chain) and tmb_div (divider)
// samples are taken one per cycle while idle; each stored one goes straight into sorted place
// after the last sample: the stored samples drain out of the head, a decision step,
// a divide for long blocks, then the result
// synchronous active-high reset empties the chain and clears the state, sample count, drain position and drop flag
`timescale 1ns / 1ps
module trimmed_mean_of_block import tmb_pkg::*; #(
   parameter int MAX_SAMPLES = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_last_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SAMPLE_BITS-1:0] rsp_mean_value,
   output logic                   rsp_overflowed
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_SAMPLES);

   // controller states
   localparam logic [2:0] ST_IDLE  = 3'd0;  // taking samples
   localparam logic [2:0] ST_DRAIN = 3'd1;  // shifting sorted block out of the head
   localparam logic [2:0] ST_CALC  = 3'd2;  // pick median or launch the divide
   localparam logic [2:0] ST_DIV   = 3'd3;  // waiting on the divider
   localparam logic [2:0] ST_OUT   = 3'd4;  // result held until its transfer

   logic [2:0]             state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;   // samples stored in this block
   logic                   ovf_ff, ovf_in;       // a sample of this block was dropped
   logic [CNT_W-1:0]       n_ff, n_in;           // block size latched at the last sample
   logic [CNT_W-1:0]       step_ff, step_in;     // drain position
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] med_ff, med_in;
   logic [SAMPLE_BITS-1:0] mean_ff, mean_in;
   logic                   ovf_out_ff, ovf_out_in;

   logic         req_xfer, rsp_xfer, room;
   cell_ctl_type ctl;
   logic         div_start, div_done;
   logic [SUM_W-1:0] div_quo;

   // chain taps
   logic [SAMPLE_BITS-1:0] val_w   [MAX_SAMPLES];
   logic                   valid_w [MAX_SAMPLES];
   logic                   take_w  [MAX_SAMPLES];

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign room      = (count_ff < CNT_W'(MAX_SAMPLES));

   assign ctl.insert = req_xfer && room;
   assign ctl.shift  = (state_ff == ST_DRAIN);

   // sorting chain, ascending from the head; empty cells sit at the tail
   for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
      logic [SAMPLE_BITS-1:0] lv, rv;
      logic                   lvalid, ltake, rvalid;
      if (i == 0) begin : g_head
         assign lv     = '0;
         assign lvalid = 1'b1;   // head always fills on insert
         assign ltake  = 1'b0;
      end else begin : g_body
         assign lv     = val_w[i-1];
         assign lvalid = valid_w[i-1];
         assign ltake  = take_w[i-1];
      end
      if (i == MAX_SAMPLES - 1) begin : g_tail
         assign rv     = '0;
         assign rvalid = 1'b0;   // empty slot shifts in at the tail
      end else begin : g_inner
         assign rv     = val_w[i+1];
         assign rvalid = valid_w[i+1];
      end
      tmb_cell #(.W(SAMPLE_BITS)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .new_sample  (req_sample),
         .left_val    (lv),
         .left_valid  (lvalid),
         .left_take   (ltake),
         .right_val   (rv),
         .right_valid (rvalid),
         .val         (val_w[i]),
         .valid       (valid_w[i]),
         .take        (take_w[i])
      );
   end

   // divides the kept sum by the kept count
   tmb_div #(.DW(SUM_W), .VW(CNT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (n_ff - CNT_W'(2 * TRIM_EACH_SIDE)),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      n_in       = n_ff;
      step_in    = step_ff;
      sum_in     = sum_ff;
      med_in     = med_ff;
      mean_in    = mean_ff;
      ovf_out_in = ovf_out_ff;
      div_start  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (room) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_sample) begin
                  // block closes: latch size and flag, reopen counters
                  n_in       = room ? (count_ff + CNT_W'(1)) : count_ff;
                  ovf_out_in = ovf_ff | !room;
                  count_in   = '0;
                  ovf_in     = 1'b0;
                  step_in    = '0;
                  sum_in     = '0;
                  med_in     = '0;
                  state_in   = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // head holds sorted element number step_ff
            if ((step_ff >= CNT_W'(TRIM_EACH_SIDE)) &&
                (step_ff < n_ff - CNT_W'(TRIM_EACH_SIDE))) begin
               sum_in = sum_ff + SUM_W'(val_w[0]);
            end
            if (step_ff == (n_ff >> 1)) begin
               med_in = val_w[0];
            end
            step_in = step_ff + CNT_W'(1);
            if (step_ff + CNT_W'(1) >= n_ff) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (n_ff >= CNT_W'(TRIM_THRESHOLD)) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               mean_in  = med_ff;
               state_in = ST_OUT;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               mean_in  = div_quo[SAMPLE_BITS-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_xfer) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         step_ff  <= step_in;
      end
      n_ff       <= n_in;
      sum_ff     <= sum_in;
      med_ff     <= med_in;
      mean_ff    <= mean_in;
      ovf_out_ff <= ovf_out_in;
   end

   assign rsp_mean_value = mean_ff;
   assign rsp_overflowed = ovf_out_ff;

endmodule

>>> dv/testbench.sv
// testbench for trimmed_mean_of_block: random sample blocks against an in-bench trimmed mean
// depends on tmb_pkg (trim constants) and the trimmed_mean_of_block rtl
`timescale 1ns / 1ps

// sorted copy of the current block plus the queue of results still owed by the block
class block_mean_tracker #(int DEPTH = 16, int WIDTH = 16);
   logic [WIDTH-1:0] sorted_block[$];
   bit               dropped;
   logic [WIDTH-1:0] mean_due[$];
   bit               overflow_due[$];
   int               errors;
   int               stored;

   function void note_sample(logic [WIDTH-1:0] sample, logic last);
      int                pos;
      int unsigned       n;
      longint unsigned   sum;
      logic [WIDTH-1:0]  mean;
      if (sorted_block.size() < DEPTH) begin
         pos = 0;
         while (pos < sorted_block.size() && sorted_block[pos] <= sample) pos++;
         sorted_block.insert(pos, sample);
         stored++;
      end else begin
         dropped = 1'b1;
      end
      if (!last) return;
      n = sorted_block.size();
      if (n < tmb_pkg::TRIM_THRESHOLD) begin
         mean = sorted_block[n / 2];
      end else begin
         sum = 0;
         for (int i = tmb_pkg::TRIM_EACH_SIDE; i < n - tmb_pkg::TRIM_EACH_SIDE; i++)
            sum += sorted_block[i];
         mean = WIDTH'(sum / (n - 2 * tmb_pkg::TRIM_EACH_SIDE));
      end
      mean_due.push_back(mean);
      overflow_due.push_back(dropped);
      sorted_block.delete();
      dropped = 1'b0;
   endfunction

   function void check_result(logic [WIDTH-1:0] mean, logic overflowed);
      if (mean_due.size() == 0) begin
         errors++;
         $display("%0t: result with none due, mean_value %0d overflowed %0b",
                  $time, mean, overflowed);
         return;
      end
      if (mean !== mean_due[0]) begin
         errors++;
         $display("%0t: mean_value expected %0d actual %0d", $time, mean_due[0], mean);
      end
      if (overflowed !== overflow_due[0]) begin
         errors++;
         $display("%0t: overflowed expected %0b actual %0b", $time, overflow_due[0],
                  overflowed);
      end
      void'(mean_due.pop_front());
      void'(overflow_due.pop_front());
   endfunction

   function int outstanding();
      return mean_due.size();
   endfunction
endclass

module testbench;
   import tmb_pkg::*;

   localparam int MAX_SAMPLES  = 16;
   localparam int SAMPLE_BITS  = 16;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
   localparam int CLK_HALF     = 6;
   localparam int RESET_CYCLES = 2;
   // random part stops once this many samples have been stored
   localparam int RANDOM_ITEMS = 850;
   // sender waits for every owed result after the first block that passes this point
   localparam int DRAIN_AT     = 450;
   // receiver holds off once this many samples went in; LONG_HOLD sets how long
   localparam int LONG_HOLD_AT = 300;
   localparam int LONG_HOLD    = 600;
   // idle slack at the end of the run before the verdict
   localparam int END_SLACK    = 100;
   localparam int CYCLE_LIMIT  = 400000;

   typedef enum {VAL_WIDE, VAL_LOW, VAL_HIGH, VAL_FLAT, VAL_EDGES} value_style_type;
   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [SAMPLE_BITS-1:0] req_sample;
   logic                   req_last_sample;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [SAMPLE_BITS-1:0] rsp_mean_value;
   logic                   rsp_overflowed;

   block_mean_tracker #(MAX_SAMPLES, SAMPLE_BITS) means = new;

   int cycles = 0;
   int burst_left = 1;

   trimmed_mean_of_block #(
      .MAX_SAMPLES(MAX_SAMPLES),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .req_last_sample(req_last_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_mean_value (rsp_mean_value),
      .rsp_overflowed (rsp_overflowed)
   );

   always begin
      #(CLK_HALF) clock = 1'b1;
      #(CLK_HALF) clock = 1'b0;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[trimmed_mean_of_block] ERROR");
         $finish;
      end
   end

   // transfer monitor: results are checked before the input of the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            means.check_result(rsp_mean_value, rsp_overflowed);
         if (req_valid && !req_stall)
            means.note_sample(req_sample, req_last_sample);
      end
   end

   // one block of samples, last flag on the final one; the sender idles in bursts
   // between transfers, or after the final sample waits until nothing is owed
   task automatic send_block(input logic [SAMPLE_BITS-1:0] vals[$], input bit drain_after);
      int gap;
      for (int i = 0; i < vals.size(); i++) begin
         req_valid       <= 1'b1;
         req_sample      <= vals[i];
         req_last_sample <= (i == vals.size() - 1);
         @(posedge clock);
         while (req_stall) @(posedge clock);
         if (i == vals.size() - 1 && drain_after) begin
            req_valid <= 1'b0;
            // the monitor may note the last sample after this edge, so look from the next one
            do @(posedge clock); while (means.outstanding() != 0);
         end else begin
            burst_left--;
            if (burst_left <= 0) begin
               // now and then a long stretch with no idling at all
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                         : $urandom_range(1, 24);
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               if (gap > 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
         end
      end
   endtask

   // receiver: stall pattern switches between random modes, plus one long hold-off
   initial begin
      stall_mode_type mode;
      int             mode_left;
      bit             held;
      mode      = STALL_NONE;
      mode_left = 0;
      held      = 1'b0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (!held && means.stored >= LONG_HOLD_AT) begin
            // block fills up and has to stall its input while the sender keeps offering
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            held = 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode      = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= ~rsp_stall;
            endcase
            @(posedge clock);
         end
      end
   end

   // sender: reset, directed blocks, random blocks, then the end of the run
   initial begin
      logic [SAMPLE_BITS-1:0] vals[$];
      logic [SAMPLE_BITS-1:0] flat;
      value_style_type        style;
      int                     len;
      int                     stored_sent;
      bit                     paused;
      bit                     drain_after;

      req_valid       <= 1'b0;
      req_sample      <= '0;
      req_last_sample <= 1'b0;
      reset           <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // single-sample blocks at both ends of the range
      vals = '{16'h0000};
      send_block(vals, 1'b0);
      vals = '{SAMPLE_MAX};
      send_block(vals, 1'b0);
      // short block: middle index of two is the larger one
      vals = '{SAMPLE_MAX, 16'h0000};
      send_block(vals, 1'b0);
      // threshold length, only the median survives the trim
      vals = '{16'd100, 16'd1, SAMPLE_MAX, 16'd50, 16'd2};
      send_block(vals, 1'b0);
      // store full: sixteen near-max samples in scrambled order, the final one is dropped;
      // middle twelve do not divide evenly so the quotient is floored
      vals.delete();
      for (int i = 0; i < MAX_SAMPLES; i++)
         vals.push_back(SAMPLE_MAX - SAMPLE_BITS'((i * 7) % MAX_SAMPLES));
      vals.push_back(16'h0000);
      send_block(vals, 1'b1);

      stored_sent = 0;
      paused      = 1'b0;
      while (stored_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: len = $urandom_range(1, MAX_SAMPLES);
            5:             len = $urandom_range(1, TRIM_THRESHOLD - 1);
            6:             len = TRIM_THRESHOLD;
            7:             len = MAX_SAMPLES;
            8:             len = $urandom_range(MAX_SAMPLES + 1, MAX_SAMPLES + 6);
            default:       len = $urandom_range(TRIM_THRESHOLD, TRIM_THRESHOLD + 3);
         endcase
         style = value_style_type'($urandom_range(0, 4));
         flat  = SAMPLE_BITS'($urandom);
         vals.delete();
         for (int i = 0; i < len; i++) begin
            case (style)
               VAL_LOW:  vals.push_back(SAMPLE_BITS'($urandom_range(0, 15)));
               VAL_HIGH: vals.push_back(SAMPLE_MAX - SAMPLE_BITS'($urandom_range(0, 15)));
               VAL_FLAT: vals.push_back(flat);
               VAL_EDGES: begin
                  case ($urandom_range(0, 2))
                     0:       vals.push_back('0);
                     1:       vals.push_back(SAMPLE_MAX);
                     default: vals.push_back(SAMPLE_BITS'($urandom));
                  endcase
               end
               default:  vals.push_back(SAMPLE_BITS'($urandom));
            endcase
         end
         stored_sent += (len < MAX_SAMPLES) ? len : MAX_SAMPLES;
         // pause once midway, and after the final block
         drain_after = (!paused && stored_sent >= DRAIN_AT) || stored_sent >= RANDOM_ITEMS;
         if (drain_after) paused = 1'b1;
         send_block(vals, drain_after);
      end

      // results are all in; let the block settle before judging
      repeat (END_SLACK) @(posedge clock);
      if (means.errors == 0 && means.outstanding() == 0) begin
         $display("[trimmed_mean_of_block] OK");
      end else begin
         $display("[trimmed_mean_of_block] ERROR");
      end
      $finish;
   end

endmodule
